>>> rtl/lltm_pkg.sv
// ---------------------------------------------------------------------------
// lltm_pkg
// Shared constants, codes and types for the LCD line and mode timing block.
// ---------------------------------------------------------------------------
package lltm_pkg;

   // display timing
   localparam int DOTS_PER_LINE = 456;
   localparam int VISIBLE_LINES = 144;
   localparam int TOTAL_LINES   = 154;
   localparam int SCAN_DOTS     = 80;
   localparam int DRAW_DOTS     = 172;

   // field widths
   localparam int DOTS_W = 8;
   localparam int LINE_W = 8;
   localparam int ROW_W  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int IRQ_EN_W    = 4;
   localparam int RSP_DATA_W  = 40;

   // dot position never reaches a full line, sum stays below two lines
   localparam int DOT_W = $clog2(DOTS_PER_LINE);
   localparam int SUM_W = DOT_W + 1;

   localparam logic [SUM_W-1:0]  LINE_DOTS  = SUM_W'(DOTS_PER_LINE);
   localparam logic [SUM_W-1:0]  SCAN_END   = SUM_W'(SCAN_DOTS);
   localparam logic [SUM_W-1:0]  DRAW_END   = SUM_W'(SCAN_DOTS + DRAW_DOTS);
   localparam logic [LINE_W-1:0] VIS_LINES  = LINE_W'(VISIBLE_LINES);
   localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(TOTAL_LINES - 1);
   localparam logic [7:0]        WINDOW_LEFT_MAX = 8'd166;

   // status request enable bits
   localparam int IRQ_HBLANK  = 0;
   localparam int IRQ_VBLANK  = 1;
   localparam int IRQ_SCAN    = 2;
   localparam int IRQ_COINC   = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LCD_ENABLE    = 3'd0,
      REG_WINDOW_ENABLE = 3'd1,
      REG_COMPARE_LINE  = 3'd2,
      REG_WINDOW_TOP    = 3'd3,
      REG_WINDOW_LEFT   = 3'd4,
      REG_STAT_IRQ_EN   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_SCAN   = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef struct packed {
      logic                lcd_enable;
      logic                window_enable;
      logic [LINE_W-1:0]   compare_line;
      logic [7:0]          window_top;
      logic [7:0]          window_left;
      logic [IRQ_EN_W-1:0] stat_irq_enables;
   } cfg_type;

   // register values after reset, display on
   localparam cfg_type CFG_RESET = '{
      lcd_enable:       1'b1,
      window_enable:    1'b0,
      compare_line:     '0,
      window_top:       '0,
      window_left:      '0,
      stat_irq_enables: '0
   };

   typedef struct packed {
      logic [LINE_W-1:0] current_line;
      mode_type          mode;
      logic              coincidence;
      logic              vblank_request;
      logic              stat_request;
      logic              line_done;
      logic [LINE_W-1:0] done_line;
      logic [ROW_W-1:0]  done_window_row;
      logic              done_window_active;
      logic              frame_complete;
      logic              hblank_entered;
   } result_type;

endpackage

>>> rtl/lcd_line_mode_timing.sv
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register frees as
// its result is taken, so input and output stall only on rsp_tready.
// Reset (synchronous, active high): dot, line, mode, compare flag and
// window state clear; registers clear except lcd_enable, which sets.
// ---------------------------------------------------------------------------
// lcd_line_mode_timing
// Scanline timing sequencer: dot/line counters, mode, status requests.
// ---------------------------------------------------------------------------
module lcd_line_mode_timing (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lltm_pkg::DOTS_W-1:0]        req_tdata,   // [7:0] dots
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] current_line, [9:8] mode, [10] coincidence, [11] vblank_request,
   // [12] stat_request, [13] line_done, [21:14] done_line,
   // [29:22] done_window_row, [30] done_window_active, [31] frame_complete,
   // [32] hblank_entered, [39:33] zero
   output logic [lltm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write port
   input  logic                               csr_we,
   input  logic [lltm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lltm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lltm_pkg::*;

   cfg_type    cfg;
   result_type step_result;
   result_type rsp_result;
   logic       can_load;
   logic       req_accept;

   assign req_tready = can_load;
   assign req_accept = req_tvalid && can_load;

   lltm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lltm_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (req_accept),
      .dots    (req_tdata),
      .result  (step_result)
   );

   lltm_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_result)
   );

   // pack result fields, first field lowest
   assign rsp_tdata = {7'b0,
                       rsp_result.hblank_entered,
                       rsp_result.frame_complete,
                       rsp_result.done_window_active,
                       rsp_result.done_window_row,
                       rsp_result.done_line,
                       rsp_result.line_done,
                       rsp_result.stat_request,
                       rsp_result.vblank_request,
                       rsp_result.coincidence,
                       rsp_result.mode,
                       rsp_result.current_line};

endmodule

>>> rtl/lltm_cfg_regs.sv
// ---------------------------------------------------------------------------
// lltm_cfg_regs
// Configuration register file, write-only, indexed writes.
// ---------------------------------------------------------------------------
module lltm_cfg_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lltm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lltm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lltm_pkg::cfg_type                 cfg
);
   import lltm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the register write, unused indexes fall through
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_LCD_ENABLE:    cfg_in.lcd_enable       = csr_wdata[0];
            REG_WINDOW_ENABLE: cfg_in.window_enable    = csr_wdata[0];
            REG_COMPARE_LINE:  cfg_in.compare_line     = csr_wdata[LINE_W-1:0];
            REG_WINDOW_TOP:    cfg_in.window_top       = csr_wdata[7:0];
            REG_WINDOW_LEFT:   cfg_in.window_left      = csr_wdata[7:0];
            REG_STAT_IRQ_EN:   cfg_in.stat_irq_enables = csr_wdata[IRQ_EN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/lltm_step.sv
// ---------------------------------------------------------------------------
// lltm_step
// Timing state (dot, line, mode, compare, window) and the one-pass update
// that turns a dot count into the next state and a result.
// ---------------------------------------------------------------------------
module lltm_step (
   input  logic                         clock,
   input  logic                         reset,
   input  lltm_pkg::cfg_type            cfg,
   input  logic                         advance,
   input  logic [lltm_pkg::DOTS_W-1:0]  dots,
   output lltm_pkg::result_type         result
);
   import lltm_pkg::*;

   logic [DOT_W-1:0]  dot_ff,   dot_in;
   logic [LINE_W-1:0] line_ff,  line_in;
   mode_type          mode_ff,  mode_in;
   logic              match_ff, match_in;
   logic [ROW_W-1:0]  row_ff,   row_in;
   logic              seen_ff,  seen_in;

   logic [SUM_W-1:0]  dot_sum;
   logic [SUM_W-1:0]  dot_wrap;
   logic              line_end;
   logic [LINE_W-1:0] line_next;
   logic              old_visible;
   logic              new_visible;
   logic              new_frame;
   logic              enter_vblank;
   logic              coinc_hit;
   logic              win_step;
   mode_type          mode_mid;
   mode_type          mode_dot;
   logic              mode_change;
   logic              hbl;
   logic [IRQ_EN_W-1:0] irq_en;

   // dot accumulation and line end
   assign irq_en      = cfg.stat_irq_enables;
   assign dot_sum     = {1'b0, dot_ff} + SUM_W'(dots);
   assign line_end    = (dot_sum >= LINE_DOTS);
   assign dot_wrap    = line_end ? (dot_sum - LINE_DOTS) : dot_sum;
   assign old_visible = (line_ff < VIS_LINES);

   // next line number, wraps at the last line
   always_comb begin
      if (!line_end) begin
         line_next = line_ff;
      end else if (line_ff == LAST_LINE) begin
         line_next = '0;
      end else begin
         line_next = line_ff + 1'b1;
      end
   end

   assign new_visible  = (line_next < VIS_LINES);
   assign new_frame    = line_end && (line_next == '0);
   assign enter_vblank = line_end && (line_next == VIS_LINES);
   assign coinc_hit    = line_end && (line_next == cfg.compare_line);
   assign win_step     = line_end && old_visible && cfg.window_enable &&
                         (line_ff >= cfg.window_top) &&
                         (cfg.window_left <= WINDOW_LEFT_MAX) && seen_ff;

   // mode after the line boundary, before the dot-based update
   always_comb begin
      if (enter_vblank) begin
         mode_mid = MODE_VBLANK;
      end else if (line_end && new_visible) begin
         mode_mid = MODE_SCAN;
      end else begin
         mode_mid = mode_ff;
      end
   end

   // mode from dot position within a visible line
   always_comb begin
      priority if (dot_wrap < SCAN_END) begin
         mode_dot = MODE_SCAN;
      end else if (dot_wrap < DRAW_END) begin
         mode_dot = MODE_DRAW;
      end else begin
         mode_dot = MODE_HBLANK;
      end
   end

   assign mode_change = new_visible && (mode_dot != mode_mid);
   assign hbl = mode_change && (mode_dot == MODE_HBLANK) && (mode_mid == MODE_DRAW);

   // next state and result
   always_comb begin
      dot_in   = dot_ff;
      line_in  = line_ff;
      mode_in  = mode_ff;
      match_in = match_ff;
      row_in   = row_ff;
      seen_in  = seen_ff;
      result   = '0;
      if (!cfg.lcd_enable) begin
         dot_in  = '0;
         line_in = '0;
         mode_in = MODE_HBLANK;
      end else begin
         dot_in  = dot_wrap[DOT_W-1:0];
         line_in = line_next;
         mode_in = mode_change ? mode_dot : mode_mid;
         if (line_end) begin
            match_in = coinc_hit;
         end
         // window row counter and window-active tracking
         if (new_frame) begin
            row_in  = '0;
            seen_in = (cfg.window_top == '0);
         end else if (win_step) begin
            row_in = row_ff + 1'b1;
         end
         if (line_end && new_visible && (line_next == cfg.window_top)) begin
            seen_in = 1'b1;
         end
         result.vblank_request = enter_vblank;
         result.frame_complete = enter_vblank;
         result.hblank_entered = hbl;
         result.stat_request   = (coinc_hit && irq_en[IRQ_COINC]) ||
                                 (enter_vblank && irq_en[IRQ_VBLANK]) ||
                                 (line_end && new_visible && irq_en[IRQ_SCAN]) ||
                                 (hbl && irq_en[IRQ_HBLANK]) ||
                                 (mode_change && (mode_dot == MODE_SCAN) &&
                                  irq_en[IRQ_SCAN]);
         if (line_end && old_visible) begin
            result.line_done          = 1'b1;
            result.done_line          = line_ff;
            result.done_window_row    = row_ff;
            result.done_window_active = seen_ff;
         end
      end
      result.current_line = line_in;
      result.mode         = mode_in;
      result.coincidence  = match_in;
   end

   // state registers move only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         line_ff  <= '0;
         mode_ff  <= MODE_HBLANK;
         match_ff <= 1'b0;
         row_ff   <= '0;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         mode_ff  <= mode_in;
         match_ff <= match_in;
         row_ff   <= row_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

>>> rtl/lltm_rsp_reg.sv
// ---------------------------------------------------------------------------
// lltm_rsp_reg
// Result register: holds one result, takes a new one as the old one leaves.
// ---------------------------------------------------------------------------
module lltm_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lltm_pkg::result_type  load_data,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lltm_pkg::result_type  rsp_data
);
   import lltm_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // free when empty or being drained this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> bench/tb_lcd_line_mode_timing.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lcd_line_mode_timing
// Drives dot counts into the line and mode timing sequencer, tracks its own
// copy of dot, line, mode, compare and window state, and checks every result.
// ---------------------------------------------------------------------------
module tb_lcd_line_mode_timing;
   import lltm_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int LONG_HOLD     = 300;
   localparam int TOTAL_REQUESTS = 950;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

   // tracks display timing state and the results still owed by the block
   class line_timing_tracker;
      logic [7:0]     cfg_compare, cfg_top, cfg_left;
      logic           cfg_lcd_on, cfg_window_on;
      logic [3:0]     cfg_irq_en;
      logic [8:0]     dot_pos;
      logic [7:0]     line_count;
      mode_type       mode_now;
      logic           match_flag;
      logic [7:0]     window_row;
      logic           window_seen;
      result_type     expected_results[$];
      int unsigned    errors;

      function new();
         cfg_lcd_on    = 1'b1;
         cfg_window_on = 1'b0;
         cfg_compare   = '0;
         cfg_top       = '0;
         cfg_left      = '0;
         cfg_irq_en    = '0;
         dot_pos       = '0;
         line_count    = '0;
         mode_now      = MODE_HBLANK;
         match_flag    = 1'b0;
         window_row    = '0;
         window_seen   = 1'b0;
         errors        = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [7:0] value);
         case (reg_index_type'(index))
            REG_LCD_ENABLE:    cfg_lcd_on    = value[0];
            REG_WINDOW_ENABLE: cfg_window_on = value[0];
            REG_COMPARE_LINE:  cfg_compare   = value;
            REG_WINDOW_TOP:    cfg_top       = value;
            REG_WINDOW_LEFT:   cfg_left      = value;
            REG_STAT_IRQ_EN:   cfg_irq_en    = value[3:0];
            default: ;
         endcase
      endfunction

      // advance the timing by one request and queue the result it owes
      function void note_request(logic [7:0] dots);
         result_type r;
         logic [9:0] pos;
         logic [7:0] line;
         mode_type   next_mode;
         r = '0;
         if (!cfg_lcd_on) begin
            line_count = '0;
            mode_now   = MODE_HBLANK;
            dot_pos    = '0;
         end else begin
            pos = 10'(dot_pos) + 10'(dots);
            if (pos >= DOTS_PER_LINE) begin
               line = line_count;
               // visible line finished, window row may step
               if (line < VISIBLE_LINES) begin
                  r.line_done          = 1'b1;
                  r.done_line          = line;
                  r.done_window_row    = window_row;
                  r.done_window_active = window_seen;
                  if (cfg_window_on && line >= cfg_top && cfg_left <= WINDOW_LEFT_MAX &&
                      window_seen)
                     window_row = window_row + 8'd1;
               end
               pos  = pos - 10'(DOTS_PER_LINE);
               line = 8'((int'(line) + 1) % TOTAL_LINES);
               line_count = line;
               // line compare
               match_flag = (line == cfg_compare);
               if (match_flag && cfg_irq_en[IRQ_COINC]) r.stat_request = 1'b1;
               // new frame
               if (line == 8'd0) begin
                  window_row  = '0;
                  window_seen = (cfg_top == 8'd0);
               end
               if (line == VISIBLE_LINES) begin
                  mode_now         = MODE_VBLANK;
                  r.vblank_request = 1'b1;
                  r.frame_complete = 1'b1;
                  if (cfg_irq_en[IRQ_VBLANK]) r.stat_request = 1'b1;
               end else if (line < VISIBLE_LINES) begin
                  mode_now = MODE_SCAN;
                  if (cfg_irq_en[IRQ_SCAN]) r.stat_request = 1'b1;
                  if (line == cfg_top) window_seen = 1'b1;
               end
            end
            dot_pos = pos[8:0];
            // mode from dot position on visible lines
            if (line_count < VISIBLE_LINES) begin
               if (dot_pos < SCAN_DOTS)
                  next_mode = MODE_SCAN;
               else if (dot_pos < SCAN_DOTS + DRAW_DOTS)
                  next_mode = MODE_DRAW;
               else
                  next_mode = MODE_HBLANK;
               if (next_mode != mode_now) begin
                  if (next_mode == MODE_HBLANK && mode_now == MODE_DRAW) begin
                     r.hblank_entered = 1'b1;
                     if (cfg_irq_en[IRQ_HBLANK]) r.stat_request = 1'b1;
                  end
                  if (next_mode == MODE_SCAN && cfg_irq_en[IRQ_SCAN]) r.stat_request = 1'b1;
                  mode_now = next_mode;
               end
            end
         end
         r.current_line = line_count;
         r.mode         = mode_now;
         r.coincidence  = match_flag;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, d);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("current_line", want.current_line, d[7:0]);
         compare_field("mode", want.mode, d[9:8]);
         compare_field("coincidence", want.coincidence, d[10]);
         compare_field("vblank_request", want.vblank_request, d[11]);
         compare_field("stat_request", want.stat_request, d[12]);
         compare_field("line_done", want.line_done, d[13]);
         compare_field("done_line", want.done_line, d[21:14]);
         compare_field("done_window_row", want.done_window_row, d[29:22]);
         compare_field("done_window_active", want.done_window_active, d[30]);
         compare_field("frame_complete", want.frame_complete, d[31]);
         compare_field("hblank_entered", want.hblank_entered, d[32]);
         compare_field("padding", 0, d[39:33]);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DOTS_W-1:0]       req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   logic                    gaps_off = 1'b0;
   logic                    hold_request = 1'b0;
   int unsigned             quiet_cycles = 0;
   int unsigned             requests_sent = 0;
   line_timing_tracker      tracker = new();

   lcd_line_mode_timing DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check, then pick next ready with random stalls or a long hold
   initial begin : receiver
      int unsigned hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request <= 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= gaps_off || ($urandom_range(99) >= 21);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("lcd_line_mode_timing regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_dots(input logic [7:0] dots);
      while (!gaps_off && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dots;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(dots);
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(index, value);
   endtask

   // all registers written while idle, spare indexes last, junk in unused bits
   task automatic apply_config(input logic lcd_on, input logic window_on,
                               input logic [7:0] compare, input logic [7:0] top,
                               input logic [7:0] left, input logic [3:0] irq_en);
      wait_for_results();
      write_register(REG_LCD_ENABLE, {7'($urandom), lcd_on});
      write_register(REG_WINDOW_ENABLE, {7'($urandom), window_on});
      write_register(REG_COMPARE_LINE, compare);
      write_register(REG_WINDOW_TOP, top);
      write_register(REG_WINDOW_LEFT, left);
      write_register(REG_STAT_IRQ_EN, {4'($urandom), irq_en});
      write_register(REG_SPARE_LOW, 8'($urandom));
      write_register(REG_SPARE_HIGH, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   // mostly large steps so frames go by, some small ones to dwell in modes
   function automatic logic [7:0] random_dots(int unsigned big_percent);
      int unsigned r;
      r = $urandom_range(99);
      if (r < big_percent) return 8'($urandom_range(255, 150));
      else if (r < big_percent + 15) return 8'($urandom_range(15));
      else return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b,
                                            logic [7:0] c, logic [7:0] d);
      case ($urandom_range(7))
         0: return a;
         1: return b;
         2: return c;
         3: return d;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic run_until_line(input logic [7:0] target);
      while (tracker.line_count != target) send_dots(random_dots(85));
   endtask

   initial begin : stimulus
      logic [7:0]  opening[$];
      int unsigned phase;
      int unsigned count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // opening: mode boundaries, line end, field extremes
      opening = '{8'd0, 8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd255, 8'd255,
                  8'd128, 8'd127, 8'd85, 8'd170, 8'd15, 8'd240};
      apply_config(1'b1, 1'b1, 8'd1, 8'd0, 8'd166, 4'hF);
      foreach (opening[i]) send_dots(opening[i]);
      // display off holds line, mode and dot at zero
      apply_config(1'b0, 1'b1, 8'd1, 8'd0, 8'd166, 4'hF);
      send_dots(8'd255);
      send_dots(8'd0);
      send_dots(8'd170);
      apply_config(1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 4'h0);
      send_dots(8'd0);
      send_dots(8'd255);

      // window row wraps: display off mid frame keeps the row, so it counts on
      apply_config(1'b0, 1'b1, 8'd0, 8'd3, 8'd7, 4'hF);
      send_dots(random_dots(50));
      send_dots(random_dots(50));
      apply_config(1'b1, 1'b1, 8'd0, 8'd3, 8'd7, 4'hF);
      run_until_line(8'(VISIBLE_LINES - 1));
      apply_config(1'b0, 1'b1, 8'd0, 8'd3, 8'd7, 4'hF);
      repeat (3) send_dots(random_dots(50));
      apply_config(1'b1, 1'b1, 8'd0, 8'd3, 8'd7, 4'($urandom));
      run_until_line(8'(VISIBLE_LINES));
      // blanking lines then a new frame
      run_until_line(8'd0);

      // random settings per phase
      phase = 0;
      while (requests_sent < TOTAL_REQUESTS) begin
         apply_config(($urandom_range(9) != 0) || (phase < 2), 1'($urandom),
                      pick_byte(8'd0, 8'd143, 8'd153, 8'd255),
                      pick_byte(8'd0, 8'd143, 8'd144, 8'd255),
                      pick_byte(8'd0, 8'd166, 8'd167, 8'd255),
                      (phase == 0) ? 4'hF : (phase == 1) ? 4'h0 : 4'($urandom));
         gaps_off <= (phase == 3);
         if (phase == 1) hold_request <= 1'b1;
         count = $urandom_range(140, 60);
         repeat (count) send_dots(random_dots(60));
         phase++;
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      if (tracker.errors == 0)
         $display("lcd_line_mode_timing regression: pass");
      else
         $display("lcd_line_mode_timing regression: fail");
      $finish;
   end

endmodule
